// ===== sv/rthit_pkg.sv =====
`timescale 1ns / 1ps
// rthit_pkg: shared types and constants for the rectangle table hit-test unit
// used by rthit_store, rthit_seq and rectangle_table_hit_test_unit; no dependencies

package rthit_pkg;

   // table depth and the widths that follow from it
   localparam int MAX_RECTS = 64;
   localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);

   // fixed widths of the result and coordinate fields
   localparam int HIT_IDX_W = 6;
   localparam int ENTRY_W   = 7;
   localparam int COORD_W   = 16;

   // request codes
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_HIT = 1'b1;

   // one stored rectangle, x in the low bits
   typedef struct packed {
      logic [COORD_W-1:0]        height;
      logic [COORD_W-1:0]        width;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } rect_entry_type;

   // write port of the rectangle memory
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rect_entry_type   data;
   } mem_wr_type;

   // read port of the rectangle memory
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

endpackage

// ===== sv/rthit_store.sv =====
`timescale 1ns / 1ps
// rthit_store: rectangle memory, one write and one registered read port
// depends on rthit_pkg

module rthit_store (
   input  logic                       clock,
   input  rthit_pkg::mem_wr_type      wr,
   input  rthit_pkg::mem_rd_type      rd,
   output rthit_pkg::rect_entry_type  rd_data
);

   rthit_pkg::rect_entry_type mem [rthit_pkg::MAX_RECTS];
   rthit_pkg::rect_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rthit_seq.sv =====
`timescale 1ns / 1ps
// rthit_seq: request sequencer - normalises adds, scans the table newest first,
// holds the entry count and the result register; depends on rthit_pkg

module rthit_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_a_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_a_y,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_b_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_b_y,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_point_y,
   output rthit_pkg::mem_wr_type                  mem_wr,
   output rthit_pkg::mem_rd_type                  mem_rd,
   input  rthit_pkg::rect_entry_type              mem_rd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit_found,
   output logic [rthit_pkg::HIT_IDX_W-1:0]        rsp_hit_index,
   output logic                                   rsp_table_full,
   output logic [rthit_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   localparam int IDX_W   = rthit_pkg::IDX_W;
   localparam int CNT_W   = rthit_pkg::CNT_W;
   localparam int COORD_W = rthit_pkg::COORD_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CHECK  = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [COORD_W-1:0] pt_x_ff, pt_x_in;
   logic signed [COORD_W-1:0] pt_y_ff, pt_y_in;
   logic                    pend_found_ff, pend_found_in;
   logic [IDX_W-1:0]        pend_index_ff, pend_index_in;
   logic                    pend_full_ff, pend_full_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [rthit_pkg::HIT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [rthit_pkg::ENTRY_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                    accept;
   logic                    table_full;
   logic [CNT_W-1:0]        cnt_dec;
   logic [IDX_W-1:0]        idx_dec;
   logic                    load_rsp;

   // add normalisation
   logic signed [COORD_W:0]   dx, dy;
   logic [COORD_W:0]          dx_neg, dy_neg;
   rthit_pkg::rect_entry_type new_entry;

   // containment test on the entry coming out of the memory
   logic signed [COORD_W+1:0] right_edge, bottom_edge;
   logic                      hit;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign table_full = (count_ff == CNT_W'(rthit_pkg::MAX_RECTS));
   assign cnt_dec    = count_ff - CNT_W'(1);
   assign idx_dec    = idx_ff - IDX_W'(1);

   always_comb begin
      dx     = (COORD_W+1)'(req_corner_a_x) - (COORD_W+1)'(req_corner_b_x);
      dy     = (COORD_W+1)'(req_corner_a_y) - (COORD_W+1)'(req_corner_b_y);
      dx_neg = -dx;
      dy_neg = -dy;
      new_entry.x      = dx[COORD_W] ? req_corner_a_x : req_corner_b_x;
      new_entry.y      = dy[COORD_W] ? req_corner_a_y : req_corner_b_y;
      new_entry.width  = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
      new_entry.height = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
   end

   always_comb begin
      right_edge  = (COORD_W+2)'(mem_rd_data.x) +
                    $signed({2'b00, mem_rd_data.width});
      bottom_edge = (COORD_W+2)'(mem_rd_data.y) +
                    $signed({2'b00, mem_rd_data.height});
      hit = (pt_x_ff > mem_rd_data.x) && ((COORD_W+2)'(pt_x_ff) < right_edge) &&
            (pt_y_ff > mem_rd_data.y) && ((COORD_W+2)'(pt_y_ff) < bottom_edge);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      pend_found_in = pend_found_ff;
      pend_index_in = pend_index_ff;
      pend_full_in  = pend_full_ff;
      mem_wr.en     = 1'b0;
      mem_wr.addr   = count_ff[IDX_W-1:0];
      mem_wr.data   = new_entry;
      mem_rd.en     = 1'b0;
      mem_rd.addr   = cnt_dec[IDX_W-1:0];
      load_rsp      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_found_in = 1'b0;
               pend_index_in = '0;
               pend_full_in  = 1'b0;
               pt_x_in       = req_point_x;
               pt_y_in       = req_point_y;
               if (req_type == rthit_pkg::REQ_ADD) begin
                  if (table_full) begin
                     pend_full_in = 1'b1;
                  end else begin
                     mem_wr.en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
                  state_in = ST_RESULT;
               end else if (count_ff == '0) begin
                  state_in = ST_RESULT;
               end else begin
                  // start with the newest entry
                  mem_rd.en = 1'b1;
                  idx_in    = cnt_dec[IDX_W-1:0];
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (hit) begin
               pend_found_in = 1'b1;
               pend_index_in = idx_ff;
               state_in      = ST_RESULT;
            end else if (idx_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = idx_dec;
               idx_in      = idx_dec;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = pend_found_ff;
         rsp_index_in = rthit_pkg::HIT_IDX_W'(pend_index_ff);
         rsp_full_in  = pend_full_ff;
         rsp_count_in = rthit_pkg::ENTRY_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pt_x_ff       <= pt_x_in;
      pt_y_ff       <= pt_y_in;
      pend_found_ff <= pend_found_in;
      pend_index_ff <= pend_index_in;
      pend_full_ff  <= pend_full_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_found   = rsp_found_ff;
   assign rsp_hit_index   = rsp_index_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_entry_count = rsp_count_ff;

   // the scan never looks past the stored entries
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond entry count");

   // an accepted add to a table with room grows the count by one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == rthit_pkg::REQ_ADD) && !table_full)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow entry count");

   // the count never exceeds the table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(rthit_pkg::MAX_RECTS))
      else $error("entry count beyond table depth");

   // a dropped add never reports a hit
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> !rsp_found_ff)
      else $error("dropped add reports a hit");

   // no new item is taken while one is in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("item accepted while another is in flight");

endmodule

// ===== sv/rectangle_table_hit_test_unit.sv =====
`timescale 1ns / 1ps
// rectangle_table_hit_test_unit: top level of the rectangle table hit-test unit
// depends on rthit_pkg, rthit_store and rthit_seq
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, req_corner_a/b_x/y, req_point_x/y
//  rsp      out        rsp_valid/rsp_stall   rsp_hit_found, rsp_hit_index,
//                                            rsp_table_full, rsp_entry_count
//
//  an add goes from acceptance through ST_RESULT into the result register; a hit test
//  scans n entries in ST_CHECK (n from 0 to MAX_RECTS), one entry a cycle through the
//  single memory read port, then goes through ST_RESULT into the result register
//  one item is in flight at a time; the next is taken once its result is in the
//  output register, so a waiting result does not hold up the next item
//  synchronous reset empties the table (count only, the memory needs no clearing);
//  rsp_stall holds the result register, the finished item waits in the sequencer

module rectangle_table_hit_test_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_a_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_a_y,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_b_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_corner_b_y,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [rthit_pkg::COORD_W-1:0]   req_point_y,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit_found,
   output logic [rthit_pkg::HIT_IDX_W-1:0]        rsp_hit_index,
   output logic                                   rsp_table_full,
   output logic [rthit_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   // memory ports between sequencer and store
   rthit_pkg::mem_wr_type     mem_wr;
   rthit_pkg::mem_rd_type     mem_rd;
   rthit_pkg::rect_entry_type mem_rd_data;

   // rectangle table: written on add, read newest to oldest during a hit test
   rthit_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   // sequencer: normalisation, scan, entry count and result register
   rthit_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_corner_a_x  (req_corner_a_x),
      .req_corner_a_y  (req_corner_a_y),
      .req_corner_b_x  (req_corner_b_x),
      .req_corner_b_y  (req_corner_b_y),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .mem_wr          (mem_wr),
      .mem_rd          (mem_rd),
      .mem_rd_data     (mem_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit_found   (rsp_hit_found),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== dv/rectangle_table_hit_test_unit_tb.sv =====
`timescale 1ns / 1ps
// rectangle_table_hit_test_unit_tb: self-checking testbench for the rectangle table hit-test unit
// depends on rthit_pkg and rectangle_table_hit_test_unit; keeps a shadow table to predict results

module rectangle_table_hit_test_unit_tb;

   localparam int COORD_W     = rthit_pkg::COORD_W;
   localparam int HIT_IDX_W   = rthit_pkg::HIT_IDX_W;
   localparam int ENTRY_W     = rthit_pkg::ENTRY_W;
   localparam int MAX_RECTS   = rthit_pkg::MAX_RECTS;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DIRECTED_N  = 25;
   localparam int AT_EMPTY_N  = 19;   // rows walked from reset, the rest once one table slot is left
   localparam int FULL_ITEMS  = 280;  // random items against the full table
   localparam int CALM_ITEMS  = 60;   // closing stretch with no idling on either side

   // one request item as driven on the req_ ports
   typedef struct packed {
      logic                      kind;
      logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
   } req_item_type;

   // one result item as seen on the rsp_ ports
   typedef struct packed {
      logic                 found;
      logic [HIT_IDX_W-1:0] idx;
      logic                 full;
      logic [ENTRY_W-1:0]   count;
   } hit_outcome_type;

   // directed stimulus row, the outcome typed in where has_want is set
   typedef struct packed {
      req_item_type    item;
      logic            has_want;
      hit_outcome_type want;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_type = rthit_pkg::REQ_ADD;
   logic signed [COORD_W-1:0] req_corner_a_x = '0;
   logic signed [COORD_W-1:0] req_corner_a_y = '0;
   logic signed [COORD_W-1:0] req_corner_b_x = '0;
   logic signed [COORD_W-1:0] req_corner_b_y = '0;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_hit_found;
   logic [HIT_IDX_W-1:0]      rsp_hit_index;
   logic                      rsp_table_full;
   logic [ENTRY_W-1:0]        rsp_entry_count;

   // shadow copy of the rectangle table
   rthit_pkg::rect_entry_type shadow_rects [MAX_RECTS];
   int                        shadow_count = 0;

   hit_outcome_type pending_outcomes [$];
   stim_row_type    directed_rows [0:DIRECTED_N-1];
   logic            typed_armed = 1'b0;
   hit_outcome_type typed_outcome = '0;

   int  cycle_count = 0;
   int  mismatches = 0;
   int  items_sent = 0;
   int  adds_taken = 0;
   int  adds_dropped = 0;
   int  hits_tested = 0;
   int  hits_found = 0;
   int  idle_pct = 0;     // chance of an idle burst for the sender, a third of it for the receiver
   bit  calm = 1'b0;      // set for the closing stretch: no gaps, no stalls
   int  stall_left = 0;

   rectangle_table_hit_test_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_corner_a_x  (req_corner_a_x),
      .req_corner_a_y  (req_corner_a_y),
      .req_corner_b_x  (req_corner_b_x),
      .req_corner_b_y  (req_corner_b_y),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit_found   (rsp_hit_found),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // apply one request to the shadow table and work out its result
   function automatic hit_outcome_type predict_request(input req_item_type rq);
      hit_outcome_type           o;
      rthit_pkg::rect_entry_type e;
      int                        ax, ay, bx, by, px, py, ex, ey, ew, eh, i;
      o = '0;
      if (rq.kind == rthit_pkg::REQ_ADD) begin
         if (shadow_count >= MAX_RECTS) begin
            // table full: item dropped, count unchanged
            o.full = 1'b1;
            adds_dropped++;
         end else begin
            ax = rq.ax;
            ay = rq.ay;
            bx = rq.bx;
            by = rq.by;
            // normalise to left/top corner plus absolute extent
            e.x      = 16'((ax < bx) ? ax : bx);
            e.y      = 16'((ay < by) ? ay : by);
            e.width  = 16'((ax > bx) ? ax - bx : bx - ax);
            e.height = 16'((ay > by) ? ay - by : by - ay);
            shadow_rects[shadow_count] = e;
            shadow_count++;
            adds_taken++;
         end
      end else begin
         hits_tested++;
         px = rq.px;
         py = rq.py;
         // newest first, strict interior only, so borders and flat rectangles never hit
         for (i = shadow_count - 1; i >= 0 && !o.found; i--) begin
            e  = shadow_rects[i];
            ex = e.x;
            ey = e.y;
            ew = e.width;
            eh = e.height;
            if (px > ex && px < ex + ew && py > ey && py < ey + eh) begin
               o.found = 1'b1;
               o.idx   = HIT_IDX_W'(i);
            end
         end
         if (o.found) begin
            hits_found++;
         end
      end
      o.count = ENTRY_W'(shadow_count);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[cycle %0d] mismatch on %s: got %0d, expected %0d",
               cycle_count, what, got, want);
   endtask

   // results are checked before the item accepted on the same edge is predicted
   always @(posedge clock) begin : scoreboard
      hit_outcome_type want;
      req_item_type    taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with nothing outstanding", 1, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_hit_found !== want.found)
                  report_mismatch("hit_found", rsp_hit_found, want.found);
               if (rsp_hit_index !== want.idx)
                  report_mismatch("hit_index", rsp_hit_index, want.idx);
               if (rsp_table_full !== want.full)
                  report_mismatch("table_full", rsp_table_full, want.full);
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", rsp_entry_count, want.count);
            end
         end
         if (req_valid && !req_stall) begin
            taken = '{req_type, req_corner_a_x, req_corner_a_y, req_corner_b_x,
                      req_corner_b_y, req_point_x, req_point_y};
            want  = predict_request(taken);
            // directed rows with has_want set carry their own outcome, the shadow table still advances
            pending_outcomes.push_back(typed_armed ? typed_outcome : want);
         end
      end
   end

   // receiver: stall bursts, started at random
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(99) < idle_pct / 3) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // drive one item from a falling edge and hold it until taken
   task automatic send_item(input req_item_type it, input logic armed,
                            input hit_outcome_type want);
      typed_armed    = armed;
      typed_outcome  = want;
      req_valid      <= 1'b1;
      req_type       <= it.kind;
      req_corner_a_x <= it.ax;
      req_corner_a_y <= it.ay;
      req_corner_b_x <= it.bx;
      req_corner_b_y <= it.by;
      req_point_x    <= it.px;
      req_point_y    <= it.py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic sender_pause(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // hold off until every outstanding result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_extreme();
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic build_random_request(input int add_pct, output req_item_type it);
      rthit_pkg::rect_entry_type e;
      int                        cx, cy, ex, ey, ew, eh;
      it = {rthit_pkg::REQ_HIT, 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom)};
      if ($urandom_range(99) < add_pct) begin
         it.kind = rthit_pkg::REQ_ADD;
         case ($urandom_range(9))
            4, 5, 6, 7: begin
               // small rectangles packed round the origin so they overlap
               cx    = int'($urandom_range(4000)) - 2000;
               cy    = int'($urandom_range(4000)) - 2000;
               it.ax = 16'(cx);
               it.ay = 16'(cy);
               it.bx = 16'(cx + int'($urandom_range(400)) - 200);
               it.by = 16'(cy + int'($urandom_range(400)) - 200);
            end
            8: begin
               if ($urandom_range(1)) it.bx = it.ax;
               else it.by = it.ay;
            end
            9: begin
               it.ax = pick_extreme();
               it.ay = pick_extreme();
               it.bx = pick_extreme();
               it.by = pick_extreme();
            end
            default: ;
         endcase
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               if (shadow_count > 0) begin
                  // aim at a stored rectangle: interior mostly, its border otherwise
                  e  = shadow_rects[$urandom_range(shadow_count - 1)];
                  ex = e.x;
                  ey = e.y;
                  ew = e.width;
                  eh = e.height;
                  it.px = 16'(ex + ((ew >= 2) ? int'($urandom_range(1, ew - 1)) : 0));
                  it.py = 16'(ey + ((eh >= 2) ? int'($urandom_range(1, eh - 1)) : 0));
                  if ($urandom_range(3) == 0) begin
                     if ($urandom_range(1)) it.px = 16'(ex + ($urandom_range(1) ? ew : 0));
                     else it.py = 16'(ey + ($urandom_range(1) ? eh : 0));
                  end
               end
            end
            6, 7: begin
               it.px = 16'(int'($urandom_range(4800)) - 2400);
               it.py = 16'(int'($urandom_range(4800)) - 2400);
            end
            8: begin
               it.px = pick_extreme();
               it.py = pick_extreme();
            end
            default: ;
         endcase
      end
   endtask

   // random items; with to_fill set, runs until one slot is left in the table
   task automatic run_random(input int add_pct, input int n_items, input bit to_fill);
      req_item_type it;
      int           k;
      k = 0;
      while (to_fill ? (shadow_count < MAX_RECTS - 1) : (k < n_items)) begin
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         if (!to_fill && k >= n_items - CALM_ITEMS) begin
            calm     = 1'b1;
            idle_pct = 0;
         end
         if (!calm && $urandom_range(99) < idle_pct) begin
            sender_pause($urandom_range(1, 7));
         end
         build_random_request(add_pct, it);
         send_item(it, 1'b0, '0);
         k++;
      end
   endtask

   initial begin : stimulus
      int r;
      directed_rows = '{
         // empty table: nothing to hit
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
         '{'{rthit_pkg::REQ_HIT, 32767, 32767, -1, -1, -32768, -32768}, 1'b1, '{0, 0, 0, 0}},
         // widest rectangle the fields allow
         '{'{rthit_pkg::REQ_ADD, -32768, -32768, 32767, 32767, 0, 0}, 1'b1, '{0, 0, 0, 1}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0}, 1'b1, '{1, 0, 0, 1}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, -32768, 0}, 1'b1, '{0, 0, 0, 1}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 32767, 32767}, 1'b1, '{0, 0, 0, 1}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, -32767, 32766}, 1'b1, '{1, 0, 0, 1}},
         // corners given high to low, point fields set but unused
         '{'{rthit_pkg::REQ_ADD, 10, 20, -10, -20, 32767, -1}, 1'b1, '{0, 0, 0, 2}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
         // on the newest rectangle's border, so the older one answers
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 10, 0}, 1'b0, '{0, 0, 0, 0}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, -20}, 1'b0, '{0, 0, 0, 0}},
         // zero width, then zero height
         '{'{rthit_pkg::REQ_ADD, 5, 5, 5, 50, 0, 0}, 1'b1, '{0, 0, 0, 3}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 5, 30}, 1'b0, '{0, 0, 0, 0}},
         '{'{rthit_pkg::REQ_ADD, -100, 7, 100, 7, 0, 0}, 1'b1, '{0, 0, 0, 4}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, 7}, 1'b0, '{0, 0, 0, 0}},
         '{'{rthit_pkg::REQ_ADD, -1, -1, 1, 1, 0, 0}, 1'b1, '{0, 0, 0, 5}},
         // corner fields set but unused by a hit test
         '{'{rthit_pkg::REQ_HIT, -32768, 32767, 32767, -32768, 0, 0}, 1'b0, '{0, 0, 0, 0}},
         // one unit wide: no integer point inside
         '{'{rthit_pkg::REQ_ADD, 1, 1, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 6}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
         // last free slot, then the highest index answers
         '{'{rthit_pkg::REQ_ADD, 30000, 30000, 30010, 30010, 0, 0}, 1'b1, '{0, 0, 0, 64}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 30005, 30005}, 1'b0, '{0, 0, 0, 0}},
         // full table refuses further adds
         '{'{rthit_pkg::REQ_ADD, 1, 2, 3, 4, 0, 0}, 1'b1, '{0, 0, 1, 64}},
         '{'{rthit_pkg::REQ_ADD, -32768, -32768, 32767, 32767, -1, -1}, 1'b1, '{0, 0, 1, 64}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, 32767, 32767}, 1'b1, '{0, 0, 0, 64}},
         '{'{rthit_pkg::REQ_HIT, 0, 0, 0, 0, -32768, -32768}, 1'b1, '{0, 0, 0, 64}}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < AT_EMPTY_N; r++) begin
         send_item(directed_rows[r].item, directed_rows[r].has_want, directed_rows[r].want);
      end
      drain_results();

      // fill the table up to one free slot with a mix of adds and hit tests
      run_random(50, 0, 1'b1);
      drain_results();

      for (r = AT_EMPTY_N; r < DIRECTED_N; r++) begin
         send_item(directed_rows[r].item, directed_rows[r].has_want, directed_rows[r].want);
      end

      // mostly hit tests on the full table, the odd refused add among them
      run_random(15, FULL_ITEMS, 1'b0);
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (MAX_RECTS + 8) @(posedge clock);

      $display("run covered %0d requests: %0d adds stored, %0d adds refused on a full table",
               items_sent, adds_taken, adds_dropped);
      $display("%0d hit tests with %0d hits, incl. extremes, borders and flat rectangles",
               hits_tested, hits_found);
      if (mismatches == 0) begin
         $display("rectangle_table_hit_test_unit verification clean");
      end else begin
         $display("rectangle_table_hit_test_unit verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout at cycle %0d with %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("rectangle_table_hit_test_unit verification failed");
      $finish;
   end

endmodule

// ===== rectangle_table_hit_test_unit.f =====
sv/rthit_pkg.sv
sv/rthit_store.sv
sv/rthit_seq.sv
sv/rectangle_table_hit_test_unit.sv
dv/rectangle_table_hit_test_unit_tb.sv
